// ===== hw/rtl/swvr_pkg.sv =====
// Shared types and codes of the value-removal stack.
package swvr_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned LevelWidth = 4;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LIST   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_REM_SCAN,
    S_REM_DONE,
    S_LIST_RD,
    S_LIST_OUT
  } state_e;

endpackage

// ===== hw/rtl/swvr_req_if.sv =====
// Request channel: request type and operand word.
interface swvr_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic signed [31:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ===== hw/rtl/swvr_rsp_if.sv =====
// Result channel: status, data word, fill level and last marker.
interface swvr_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [3:0]         level;
  logic               last;

  modport source (output valid, output status, output data, output level, output last,
                  input ready);
  modport sink   (input valid, input status, input data, input level, input last,
                  output ready);
endinterface

// ===== hw/rtl/stack_with_value_removal_core.sv =====
// One request at a time: a new request is taken only in idle, once the last result is registered.
// Pop reads the top entry and then emits it; removal walks every stored entry once;
// listing reads and then emits each entry in turn, from the top down.
// The pace is set by the one-read one-write entry memory, whose read is registered.
// Reset clears the fill level and control state; entry memory stays unknown
// until written, with no clearing pass.
module stack_with_value_removal_core
  import swvr_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swvr_req_if.sink    req_i,
  swvr_rsp_if.source  rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  state_e state_q, state_d;

  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [CW-1:0] wr_q, wr_d;
  logic          rv_q, rv_d;

  req_e                  req_q;
  logic [DataWidth-1:0]  value_q;

  logic [DataWidth-1:0]  mem_q [DEPTH];
  logic [DataWidth-1:0]  rdata_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DataWidth-1:0]  mem_wdata;

  logic                  rsp_valid_q, rsp_valid_d;
  status_e               rsp_status_q, emit_status;
  logic [DataWidth-1:0]  rsp_data_q, emit_data;
  logic [LevelWidth-1:0] rsp_level_q;
  logic                  rsp_last_q, emit_last;
  logic                  emit;
  logic [CW-1:0]         emit_level;
  logic [CW+LevelWidth-1:0] level_ext;

  logic          out_free, empty, full, rd_more;
  logic [CW-1:0] fill_m1;

  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign empty    = (fill_q == '0);
  assign full     = (fill_q == CW'(DEPTH));
  assign rd_more  = (ptr_q < fill_q);
  assign fill_m1  = fill_q - 1'b1;

  assign req_i.ready = (state_q == S_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        case (req_q)
          REQ_PUSH: begin
            if (out_free) state_d = S_IDLE;
          end
          REQ_POP: begin
            if (!empty)        state_d = S_POP_WAIT;
            else if (out_free) state_d = S_IDLE;
          end
          REQ_REMOVE: begin
            if (!empty)        state_d = S_REM_SCAN;
            else if (out_free) state_d = S_IDLE;
          end
          REQ_LIST: begin
            if (!empty)        state_d = S_LIST_RD;
            else if (out_free) state_d = S_IDLE;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_POP_WAIT: begin
        if (out_free) state_d = S_IDLE;
      end
      S_REM_SCAN: begin
        if (!rd_more && !rv_q) state_d = S_REM_DONE;
      end
      S_REM_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      S_LIST_RD: begin
        state_d = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (out_free) state_d = (ptr_q == '0) ? S_IDLE : S_LIST_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    emit        = 1'b0;
    emit_status = STAT_OK;
    emit_data   = '0;
    emit_level  = fill_q;
    emit_last   = 1'b1;
    mem_we      = 1'b0;
    mem_waddr   = fill_q[AW-1:0];
    mem_wdata   = value_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q[AW-1:0];
    fill_d      = fill_q;
    ptr_d       = ptr_q;
    wr_d        = wr_q;
    rv_d        = 1'b0;
    case (state_q)
      S_EXEC: begin
        case (req_q)
          REQ_PUSH: begin
            if (out_free) begin
              emit = 1'b1;
              if (full) begin
                emit_status = STAT_FULL;
              end else begin
                mem_we     = 1'b1;
                fill_d     = fill_q + 1'b1;
                emit_level = fill_q + 1'b1;
              end
            end
          end
          REQ_POP: begin
            if (empty) begin
              emit        = out_free;
              emit_status = STAT_EMPTY;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = fill_m1[AW-1:0];
            end
          end
          REQ_REMOVE: begin
            if (empty) begin
              emit        = out_free;
              emit_status = STAT_EMPTY;
            end else begin
              ptr_d = '0;
              wr_d  = '0;
            end
          end
          REQ_LIST: begin
            if (empty) begin
              emit        = out_free;
              emit_status = STAT_EMPTY;
            end else begin
              ptr_d = fill_m1;
            end
          end
          default: ;
        endcase
      end
      S_POP_WAIT: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_data  = rdata_q;
          emit_level = fill_m1;
          fill_d     = fill_m1;
        end
      end
      S_REM_SCAN: begin
        if (rd_more) begin
          mem_re = 1'b1;
          ptr_d  = ptr_q + 1'b1;
          rv_d   = 1'b1;
        end
        // write index trails the read index, so the squeeze never overtakes a pending read
        if (rv_q && (rdata_q != value_q)) begin
          mem_we    = 1'b1;
          mem_waddr = wr_q[AW-1:0];
          mem_wdata = rdata_q;
          wr_d      = wr_q + 1'b1;
        end
      end
      S_REM_DONE: begin
        if (out_free) begin
          emit = 1'b1;
          if (wr_q == fill_q) begin
            emit_status = STAT_NOTFOUND;
          end else begin
            fill_d     = wr_q;
            emit_level = wr_q;
          end
        end
      end
      S_LIST_RD: begin
        mem_re = 1'b1;
      end
      S_LIST_OUT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_data = rdata_q;
          emit_last = (ptr_q == '0);
          if (ptr_q != '0) ptr_d = ptr_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign level_ext   = {{LevelWidth{1'b0}}, emit_level};
  assign rsp_valid_d = emit ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      ptr_q       <= '0;
      wr_q        <= '0;
      rv_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      wr_q        <= wr_d;
      rv_q        <= rv_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q   <= req_e'(req_i.req_type);
      value_q <= req_i.value;
    end
    if (emit) begin
      rsp_status_q <= emit_status;
      rsp_data_q   <= emit_data;
      rsp_level_q  <= level_ext[LevelWidth-1:0];
      rsp_last_q   <= emit_last;
    end
  end

  // Entry memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.data   = rsp_data_q;
  assign rsp_o.level  = rsp_level_q;
  assign rsp_o.last   = rsp_last_q;

endmodule

// ===== bench/stack_with_value_removal_core_tb.sv =====
// Self-checking testbench for the value-removal stack core: directed table plus random requests.
module stack_with_value_removal_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swvr_pkg::*;

  localparam int unsigned Depth       = 8;
  localparam int unsigned RandomReqs  = 250;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned NumDirected = 26;

  typedef struct {
    status_e               status;
    logic [DataWidth-1:0]  data;
    logic [LevelWidth-1:0] level;
    logic                  last;
  } rsp_t;

  // fixed rows carry a typed-in single result (data zero, last set)
  typedef struct {
    req_e                  op;
    logic [DataWidth-1:0]  operand;
    bit                    fixed;
    status_e               status;
    logic [LevelWidth-1:0] level;
  } dir_row_t;

  localparam logic [DataWidth-1:0] ValuePool [6] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h5A5A_A5A5
  };

  dir_row_t dir_tbl [NumDirected] = '{
    '{REQ_POP,    32'h0000_0000, 1'b1, STAT_EMPTY,    4'd0},
    '{REQ_REMOVE, 32'h0000_0000, 1'b1, STAT_EMPTY,    4'd0},
    '{REQ_LIST,   32'h0000_0000, 1'b1, STAT_EMPTY,    4'd0},
    '{REQ_PUSH,   32'h7FFF_FFFF, 1'b1, STAT_OK,       4'd1},
    '{REQ_PUSH,   32'h8000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'hFFFF_FFFF, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'h0000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'h8000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'h5555_5555, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'hAAAA_AAAA, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'h8000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'h0000_0001, 1'b1, STAT_FULL,     4'd8},
    '{REQ_LIST,   32'h0000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_REMOVE, 32'h0000_3039, 1'b1, STAT_NOTFOUND, 4'd8},
    '{REQ_REMOVE, 32'h8000_0000, 1'b1, STAT_OK,       4'd5},
    '{REQ_LIST,   32'h0000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_POP,    32'h0000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_REMOVE, 32'h7FFF_FFFF, 1'b0, STAT_OK,       4'd0},
    '{REQ_POP,    32'h0000_0000, 1'b0, STAT_OK,       4'd0},
    '{REQ_POP,    32'h0000_0000, 1'b0, STAT_OK,       4'd0},
    // single entry left: removal must match it and leave the stack empty
    '{REQ_REMOVE, 32'hFFFF_FFFF, 1'b1, STAT_OK,       4'd0},
    '{REQ_LIST,   32'h0000_0000, 1'b1, STAT_EMPTY,    4'd0},
    '{REQ_PUSH,   32'h0000_0009, 1'b0, STAT_OK,       4'd0},
    '{REQ_PUSH,   32'h0000_0009, 1'b0, STAT_OK,       4'd0},
    '{REQ_REMOVE, 32'h0000_0009, 1'b1, STAT_OK,       4'd0},
    '{REQ_POP,    32'h0000_0000, 1'b1, STAT_EMPTY,    4'd0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  swvr_req_if req_bus ();
  swvr_rsp_if rsp_bus ();

  stack_with_value_removal_core #(
    .DEPTH(Depth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  logic [DataWidth-1:0] stack_words [Depth];
  int unsigned          stack_fill = 0;
  rsp_t                 step_rsp [Depth];
  rsp_t                 expected_q [$];
  int unsigned          fail_cnt  = 0;
  int unsigned          cycle_cnt = 0;
  bit                   quiet_mode = 1'b0;

  // Stack behavior; fills step_rsp and returns the number of results.
  function automatic int predict_request(req_e op, logic [DataWidth-1:0] operand);
    int unsigned keep;
    int unsigned n;
    case (op)
      REQ_PUSH: begin
        if (stack_fill >= Depth) begin
          step_rsp[0] = '{STAT_FULL, 32'd0, LevelWidth'(stack_fill), 1'b1};
        end else begin
          stack_words[stack_fill] = operand;
          stack_fill++;
          step_rsp[0] = '{STAT_OK, 32'd0, LevelWidth'(stack_fill), 1'b1};
        end
        return 1;
      end
      REQ_POP: begin
        if (stack_fill == 0) begin
          step_rsp[0] = '{STAT_EMPTY, 32'd0, 4'd0, 1'b1};
        end else begin
          stack_fill--;
          step_rsp[0] = '{STAT_OK, stack_words[stack_fill], LevelWidth'(stack_fill), 1'b1};
        end
        return 1;
      end
      REQ_REMOVE: begin
        if (stack_fill == 0) begin
          step_rsp[0] = '{STAT_EMPTY, 32'd0, 4'd0, 1'b1};
          return 1;
        end
        keep = 0;
        for (int unsigned i = 0; i < stack_fill; i++) begin
          if (stack_words[i] != operand) begin
            stack_words[keep] = stack_words[i];
            keep++;
          end
        end
        if (keep == stack_fill) begin
          step_rsp[0] = '{STAT_NOTFOUND, 32'd0, LevelWidth'(stack_fill), 1'b1};
        end else begin
          stack_fill  = keep;
          step_rsp[0] = '{STAT_OK, 32'd0, LevelWidth'(stack_fill), 1'b1};
        end
        return 1;
      end
      default: begin
        if (stack_fill == 0) begin
          step_rsp[0] = '{STAT_EMPTY, 32'd0, 4'd0, 1'b1};
          return 1;
        end
        n = stack_fill;
        for (int unsigned i = 0; i < n; i++) begin
          step_rsp[i] = '{STAT_OK, stack_words[n-1-i], LevelWidth'(n), (i + 1 == n)};
        end
        return int'(n);
      end
    endcase
  endfunction

  // mostly short gaps, a few long ones; none while quiet
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(req_e op, logic [DataWidth-1:0] operand, bit fixed,
                              status_e status, logic [LevelWidth-1:0] level);
    int unsigned gap;
    int          n;
    gap = pick_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= op;
    req_bus.value    <= operand;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    n = predict_request(op, operand);
    if (fixed) begin
      expected_q.push_back('{status, 32'd0, level, 1'b1});
    end else begin
      for (int i = 0; i < n; i++) expected_q.push_back(step_rsp[i]);
    end
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned          gap;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: status %0d data %h level %0d last %0b",
               rsp_bus.status, rsp_bus.data, rsp_bus.level, rsp_bus.last);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (rsp_bus.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
          fail_cnt++;
        end
        if (rsp_bus.data !== want.data) begin
          $error("data: expected %h, got %h", want.data, rsp_bus.data);
          fail_cnt++;
        end
        if (rsp_bus.level !== want.level) begin
          $error("level: expected %0d, got %0d", want.level, rsp_bus.level);
          fail_cnt++;
        end
        if (rsp_bus.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp_bus.last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int unsigned          pick;
    req_e                 op;
    logic [DataWidth-1:0] operand;
    bit                   fill_phase;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_PUSH;
    req_bus.value    = '0;
    fill_phase       = 1'b1;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) begin
      send_request(dir_tbl[i].op, dir_tbl[i].operand, dir_tbl[i].fixed,
                   dir_tbl[i].status, dir_tbl[i].level);
    end

    for (int k = 0; k < RandomReqs; k++) begin
      // pick a filling or draining phase at random so full and empty both get hit
      if (k % 25 == 0) begin
        fill_phase = $urandom_range(0, 1);
        quiet_mode = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (fill_phase) begin
        op = (pick < 55) ? REQ_PUSH : (pick < 65) ? REQ_POP : (pick < 85) ? REQ_REMOVE : REQ_LIST;
      end else begin
        op = (pick < 15) ? REQ_PUSH : (pick < 55) ? REQ_POP : (pick < 85) ? REQ_REMOVE : REQ_LIST;
      end
      operand = $urandom();
      // small value pool makes duplicates, so removals squeeze several entries
      if (op == REQ_PUSH && $urandom_range(0, 1) == 1) begin
        operand = ValuePool[$urandom_range(0, 5)];
      end
      if (op == REQ_REMOVE && stack_fill > 0 && $urandom_range(0, 9) < 7) begin
        operand = stack_words[$urandom_range(0, stack_fill - 1)];
      end
      send_request(op, operand, 1'b0, STAT_OK, 4'd0);
    end
    req_bus.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
